[rtl/core/smvf_pkg.sv]
`default_nettype none

package smvf_pkg;

    // Internal number format: signed Q46.16 in 64 bits, symmetric clamp.
    typedef logic signed [63:0] fx_t;

    typedef struct packed {
        logic sat;
        fx_t  val;
    } fx_res_t;

    typedef logic [1:0] slot_t;

    localparam slot_t SLOT_C0   = 2'd0;
    localparam slot_t SLOT_C1   = 2'd1;
    localparam slot_t SLOT_C2   = 2'd2;
    localparam slot_t SLOT_NONE = 2'd3;

    localparam int unsigned MUL_LAT = 4;

    localparam fx_t FX_LIM      = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam fx_t FX_LIM_NEG  = 64'shC000_0000_0000_0001;
    localparam fx_t FX_HALF     = 64'sh0000_0000_0000_8000;
    localparam fx_t FX_ONE_NEG  = 64'shFFFF_FFFF_FFFF_0000;
    localparam fx_t OUT_SMAX    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam fx_t OUT_SMIN    = 64'shFFFF_8000_0000_0000;
    localparam fx_t HESS_MAX    = 64'sh0000_FFFF_FFFF_FFFF;

    localparam logic signed [64:0] FX_LIM_W     = 65'sh0_3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] FX_LIM_NEG_W = 65'sh1_C000_0000_0000_0001;

    // Clamped add.
    function automatic fx_res_t fx_add(input fx_t a, input fx_t b);
        logic signed [64:0] s;
        fx_res_t r;
        s = {a[63], a} + {b[63], b};
        r.sat = 1'b0;
        r.val = s[63:0];
        if (s > FX_LIM_W) begin
            r.sat = 1'b1;
            r.val = FX_LIM;
        end else if (s < FX_LIM_NEG_W) begin
            r.sat = 1'b1;
            r.val = FX_LIM_NEG;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/stvk_membrane_vertex_force.sv]
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+------------------------------------------
// s_        | in        | s_valid / s_ready   | edges, inverse rest matrix, area, slot
// m_        | out       | m_valid / m_ready   | force_grad_x/y/z, hessian_diag, saturated
// cfg_      | in        | cfg_wr_en           | cfg_index, cfg_data (mu, lambda)
//
// One element per cycle sustained while the output slot is free or taken.
// Depth set by the 4-stage multiplier units chained seven deep plus the add stages.
// aresetn (synchronous, active low) clears config, valid bits and output valid.
// Whole pipeline freezes while a result waits untaken; nothing is lost or repeated.
`default_nettype none

module stvk_membrane_vertex_force (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_index,
    input  wire logic [47:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_edge1_x,
    input  wire logic signed [31:0] s_edge1_y,
    input  wire logic signed [31:0] s_edge1_z,
    input  wire logic signed [31:0] s_edge2_x,
    input  wire logic signed [31:0] s_edge2_y,
    input  wire logic signed [31:0] s_edge2_z,
    input  wire logic signed [31:0] s_inv_rest_00,
    input  wire logic signed [31:0] s_inv_rest_01,
    input  wire logic signed [31:0] s_inv_rest_10,
    input  wire logic signed [31:0] s_inv_rest_11,
    input  wire logic [31:0]        s_rest_area,
    input  wire logic [1:0]         s_corner_slot,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [47:0]      m_force_grad_x,
    output logic signed [47:0]      m_force_grad_y,
    output logic signed [47:0]      m_force_grad_z,
    output logic [47:0]             m_hessian_diag,
    output logic                    m_saturated
);

    localparam int unsigned STAGES = 37;

    // Config registers
    localparam logic CFG_MU  = 1'b0;
    localparam logic CFG_LAM = 1'b1;

    logic [47:0] mu_reg, lam_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_reg  <= '0;
            lam_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MU:  mu_reg  <= cfg_data;
                CFG_LAM: lam_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    smvf_pkg::fx_t twomu, lam, tml;
    assign twomu = {15'd0, mu_reg, 1'b0};   // 2 * mu is exact
    assign lam   = {16'd0, lam_reg};
    assign tml   = twomu + lam;

    // Global stall: the pipe advances whenever the output slot is free or taken.
    logic              en;
    logic [STAGES-1:0] vld_reg;

    assign en      = !vld_reg[STAGES-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], s_valid};
        end
    end

    // Stage 0: operands straight from the ports
    smvf_pkg::fx_t d1 [3];
    smvf_pkg::fx_t d2 [3];
    smvf_pkg::fx_t m00, m01, m10, m11, area, gx, gy;

    assign d1[0] = 64'(s_edge1_x);
    assign d1[1] = 64'(s_edge1_y);
    assign d1[2] = 64'(s_edge1_z);
    assign d2[0] = 64'(s_edge2_x);
    assign d2[1] = 64'(s_edge2_y);
    assign d2[2] = 64'(s_edge2_z);
    assign m00   = 64'(s_inv_rest_00);
    assign m01   = 64'(s_inv_rest_01);
    assign m10   = 64'(s_inv_rest_10);
    assign m11   = 64'(s_inv_rest_11);
    assign area  = {32'd0, s_rest_area};

    // Shape-function gradient of the chosen corner
    always_comb begin
        unique case (s_corner_slot)
            smvf_pkg::SLOT_C1: begin
                gx = m00;
                gy = m01;
            end
            smvf_pkg::SLOT_C2: begin
                gx = m10;
                gy = m11;
            end
            default: begin
                gx = -(m00 + m10);
                gy = -(m01 + m11);
            end
        endcase
    end

    // Level A: F = [d1 d2] * Minv products, |g|^2 terms, area * (2mu + lambda)
    smvf_pkg::fx_t pa [3][4];
    logic          sa [3][4];
    smvf_pkg::fx_t gxx, gyy, ka;
    logic          s_gxx, s_gyy, s_ka;

    for (genvar i = 0; i < 3; i++) begin : g_la
        smvf_fmul u_m0 (.aclk, .en, .a(d1[i]), .b(m00), .p(pa[i][0]), .sat(sa[i][0]));
        smvf_fmul u_m1 (.aclk, .en, .a(d2[i]), .b(m10), .p(pa[i][1]), .sat(sa[i][1]));
        smvf_fmul u_m2 (.aclk, .en, .a(d1[i]), .b(m01), .p(pa[i][2]), .sat(sa[i][2]));
        smvf_fmul u_m3 (.aclk, .en, .a(d2[i]), .b(m11), .p(pa[i][3]), .sat(sa[i][3]));
    end

    smvf_fmul u_gxx (.aclk, .en, .a(gx),   .b(gx),  .p(gxx), .sat(s_gxx));
    smvf_fmul u_gyy (.aclk, .en, .a(gy),   .b(gy),  .p(gyy), .sat(s_gyy));
    smvf_fmul u_ka  (.aclk, .en, .a(area), .b(tml), .p(ka),  .sat(s_ka));

    // Stage 5: columns of F
    smvf_pkg::fx_t   fc0_reg [3];
    smvf_pkg::fx_t   fc1_reg [3];
    smvf_pkg::fx_t   hs_reg, ka_reg;
    logic            sat5_reg;
    smvf_pkg::fx_res_t ra0 [3];
    smvf_pkg::fx_res_t ra1 [3];
    smvf_pkg::fx_res_t rhs;
    logic            sat5_next;

    always_comb begin
        rhs       = smvf_pkg::fx_add(gxx, gyy);
        sat5_next = s_gxx | s_gyy | s_ka | rhs.sat;
        for (int i = 0; i < 3; i++) begin
            ra0[i]    = smvf_pkg::fx_add(pa[i][0], pa[i][1]);
            ra1[i]    = smvf_pkg::fx_add(pa[i][2], pa[i][3]);
            sat5_next = sat5_next | ra0[i].sat | ra1[i].sat
                        | sa[i][0] | sa[i][1] | sa[i][2] | sa[i][3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                fc0_reg[i] <= ra0[i].val;
                fc1_reg[i] <= ra1[i].val;
            end
            hs_reg   <= rhs.val;
            ka_reg   <= ka;
            sat5_reg <= sat5_next;
        end
    end

    // Level B: F^T F products and Hessian term
    smvf_pkg::fx_t q00 [3];
    smvf_pkg::fx_t q01 [3];
    smvf_pkg::fx_t q11 [3];
    logic          t00 [3];
    logic          t01 [3];
    logic          t11 [3];
    smvf_pkg::fx_t k9;
    logic          s_k9, sat9;

    for (genvar i = 0; i < 3; i++) begin : g_lb
        smvf_fmul u_q00 (.aclk, .en, .a(fc0_reg[i]), .b(fc0_reg[i]),
                         .p(q00[i]), .sat(t00[i]));
        smvf_fmul u_q01 (.aclk, .en, .a(fc0_reg[i]), .b(fc1_reg[i]),
                         .p(q01[i]), .sat(t01[i]));
        smvf_fmul u_q11 (.aclk, .en, .a(fc1_reg[i]), .b(fc1_reg[i]),
                         .p(q11[i]), .sat(t11[i]));
    end

    smvf_fmul u_k (.aclk, .en, .a(ka_reg), .b(hs_reg), .p(k9), .sat(s_k9));

    smvf_dly #(.W(1), .N(smvf_pkg::MUL_LAT)) u_sat9 (
        .aclk, .en, .d(sat5_reg), .q(sat9)
    );

    // Stages 10 to 12: dot sums in x, y, z order, then minus one on the diagonal
    smvf_pkg::fx_t   a00_reg, a01_reg, a11_reg, c00_reg, c01_reg, c11_reg;
    smvf_pkg::fx_t   b00_reg, b01_reg, b11_reg;
    smvf_pkg::fx_t   e00_reg, e01_reg, e11_reg;
    logic            sat10_reg, sat11_reg, sat12_reg;
    smvf_pkg::fx_res_t r10_00, r10_01, r10_11, r11_00, r11_01, r11_11, r12_00, r12_11;

    always_comb begin
        r10_00 = smvf_pkg::fx_add(q00[0], q00[1]);
        r10_01 = smvf_pkg::fx_add(q01[0], q01[1]);
        r10_11 = smvf_pkg::fx_add(q11[0], q11[1]);
        r11_00 = smvf_pkg::fx_add(a00_reg, c00_reg);
        r11_01 = smvf_pkg::fx_add(a01_reg, c01_reg);
        r11_11 = smvf_pkg::fx_add(a11_reg, c11_reg);
        r12_00 = smvf_pkg::fx_add(b00_reg, smvf_pkg::FX_ONE_NEG);
        r12_11 = smvf_pkg::fx_add(b11_reg, smvf_pkg::FX_ONE_NEG);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a00_reg   <= r10_00.val;
            a01_reg   <= r10_01.val;
            a11_reg   <= r10_11.val;
            c00_reg   <= q00[2];
            c01_reg   <= q01[2];
            c11_reg   <= q11[2];
            sat10_reg <= sat9 | s_k9 | r10_00.sat | r10_01.sat | r10_11.sat
                         | t00[0] | t00[1] | t00[2] | t01[0] | t01[1] | t01[2]
                         | t11[0] | t11[1] | t11[2];
            b00_reg   <= r11_00.val;
            b01_reg   <= r11_01.val;
            b11_reg   <= r11_11.val;
            sat11_reg <= sat10_reg | r11_00.sat | r11_01.sat | r11_11.sat;
            e00_reg   <= r12_00.val;
            e01_reg   <= b01_reg;
            e11_reg   <= r12_11.val;
            sat12_reg <= sat11_reg | r12_00.sat | r12_11.sat;
        end
    end

    // Level C: Green strain
    smvf_pkg::fx_t g00, g01, g11;
    logic          s_g00, s_g01, s_g11, sat16;

    smvf_fmul u_g00 (.aclk, .en, .a(smvf_pkg::FX_HALF), .b(e00_reg), .p(g00), .sat(s_g00));
    smvf_fmul u_g01 (.aclk, .en, .a(smvf_pkg::FX_HALF), .b(e01_reg), .p(g01), .sat(s_g01));
    smvf_fmul u_g11 (.aclk, .en, .a(smvf_pkg::FX_HALF), .b(e11_reg), .p(g11), .sat(s_g11));

    smvf_dly #(.W(1), .N(smvf_pkg::MUL_LAT)) u_sat16 (
        .aclk, .en, .d(sat12_reg), .q(sat16)
    );

    // Stage 17: trace
    smvf_pkg::fx_t   g00_reg, g01_reg, g11_reg, trg_reg;
    logic            sat17_reg;
    smvf_pkg::fx_res_t rtr;

    assign rtr = smvf_pkg::fx_add(g00, g11);

    always_ff @(posedge aclk) begin
        if (en) begin
            g00_reg   <= g00;
            g01_reg   <= g01;
            g11_reg   <= g11;
            trg_reg   <= rtr.val;
            sat17_reg <= sat16 | s_g00 | s_g01 | s_g11 | rtr.sat;
        end
    end

    // Level D: SVK stress
    smvf_pkg::fx_t u00, ltr, s01, u11;
    logic          s_u00, s_ltr, s_s01, s_u11, sat21;

    smvf_fmul u_u00 (.aclk, .en, .a(twomu), .b(g00_reg), .p(u00), .sat(s_u00));
    smvf_fmul u_ltr (.aclk, .en, .a(lam),   .b(trg_reg), .p(ltr), .sat(s_ltr));
    smvf_fmul u_s01 (.aclk, .en, .a(twomu), .b(g01_reg), .p(s01), .sat(s_s01));
    smvf_fmul u_u11 (.aclk, .en, .a(twomu), .b(g11_reg), .p(u11), .sat(s_u11));

    smvf_dly #(.W(1), .N(smvf_pkg::MUL_LAT)) u_sat21 (
        .aclk, .en, .d(sat17_reg), .q(sat21)
    );

    // Stage 22
    smvf_pkg::fx_t   s00_reg, s01_reg, s11_reg;
    logic            sat22_reg;
    smvf_pkg::fx_res_t rs00, rs11;

    assign rs00 = smvf_pkg::fx_add(u00, ltr);
    assign rs11 = smvf_pkg::fx_add(u11, ltr);

    always_ff @(posedge aclk) begin
        if (en) begin
            s00_reg   <= rs00.val;
            s01_reg   <= s01;
            s11_reg   <= rs11.val;
            sat22_reg <= sat21 | s_u00 | s_ltr | s_s01 | s_u11 | rs00.sat | rs11.sat;
        end
    end

    // F columns wait for the stress
    smvf_pkg::fx_t fc0d [3];
    smvf_pkg::fx_t fc1d [3];

    for (genvar i = 0; i < 3; i++) begin : g_fcd
        smvf_dly #(.W(64), .N(17)) u_d0 (.aclk, .en, .d(fc0_reg[i]), .q(fc0d[i]));
        smvf_dly #(.W(64), .N(17)) u_d1 (.aclk, .en, .d(fc1_reg[i]), .q(fc1d[i]));
    end

    // Level E: P = F S
    smvf_pkg::fx_t pe [3][4];
    logic          se [3][4];
    logic          sat26;

    for (genvar i = 0; i < 3; i++) begin : g_le
        smvf_fmul u_e0 (.aclk, .en, .a(fc0d[i]), .b(s00_reg), .p(pe[i][0]), .sat(se[i][0]));
        smvf_fmul u_e1 (.aclk, .en, .a(fc1d[i]), .b(s01_reg), .p(pe[i][1]), .sat(se[i][1]));
        smvf_fmul u_e2 (.aclk, .en, .a(fc0d[i]), .b(s01_reg), .p(pe[i][2]), .sat(se[i][2]));
        smvf_fmul u_e3 (.aclk, .en, .a(fc1d[i]), .b(s11_reg), .p(pe[i][3]), .sat(se[i][3]));
    end

    smvf_dly #(.W(1), .N(smvf_pkg::MUL_LAT)) u_sat26 (
        .aclk, .en, .d(sat22_reg), .q(sat26)
    );

    // Stage 27
    smvf_pkg::fx_t   pc0_reg [3];
    smvf_pkg::fx_t   pc1_reg [3];
    logic            sat27_reg;
    smvf_pkg::fx_res_t rp0 [3];
    smvf_pkg::fx_res_t rp1 [3];
    logic            sat27_next;

    always_comb begin
        sat27_next = sat26;
        for (int i = 0; i < 3; i++) begin
            rp0[i]     = smvf_pkg::fx_add(pe[i][0], pe[i][1]);
            rp1[i]     = smvf_pkg::fx_add(pe[i][2], pe[i][3]);
            sat27_next = sat27_next | rp0[i].sat | rp1[i].sat
                         | se[i][0] | se[i][1] | se[i][2] | se[i][3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pc0_reg[i] <= rp0[i].val;
                pc1_reg[i] <= rp1[i].val;
            end
            sat27_reg <= sat27_next;
        end
    end

    // Corner gradient and area travel alongside
    smvf_pkg::fx_t gxd, gyd, aread, k36;
    logic [1:0]    slot36;

    smvf_dly #(.W(64), .N(27)) u_gxd   (.aclk, .en, .d(gx),   .q(gxd));
    smvf_dly #(.W(64), .N(27)) u_gyd   (.aclk, .en, .d(gy),   .q(gyd));
    smvf_dly #(.W(64), .N(32)) u_aread (.aclk, .en, .d(area), .q(aread));
    smvf_dly #(.W(64), .N(27)) u_kd    (.aclk, .en, .d(k9),   .q(k36));
    smvf_dly #(.W(2),  .N(36)) u_slotd (.aclk, .en, .d(s_corner_slot), .q(slot36));

    // Level F: P * g_s
    smvf_pkg::fx_t pf [3][2];
    logic          sf [3][2];
    logic          sat31;

    for (genvar i = 0; i < 3; i++) begin : g_lf
        smvf_fmul u_f0 (.aclk, .en, .a(pc0_reg[i]), .b(gxd), .p(pf[i][0]), .sat(sf[i][0]));
        smvf_fmul u_f1 (.aclk, .en, .a(pc1_reg[i]), .b(gyd), .p(pf[i][1]), .sat(sf[i][1]));
    end

    smvf_dly #(.W(1), .N(smvf_pkg::MUL_LAT)) u_sat31 (
        .aclk, .en, .d(sat27_reg), .q(sat31)
    );

    // Stage 32
    smvf_pkg::fx_t   gs_reg [3];
    logic            sat32_reg;
    smvf_pkg::fx_res_t rg [3];
    logic            sat32_next;

    always_comb begin
        sat32_next = sat31;
        for (int i = 0; i < 3; i++) begin
            rg[i]      = smvf_pkg::fx_add(pf[i][0], pf[i][1]);
            sat32_next = sat32_next | rg[i].sat | sf[i][0] | sf[i][1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                gs_reg[i] <= rg[i].val;
            end
            sat32_reg <= sat32_next;
        end
    end

    // Level G: scale by rest area
    smvf_pkg::fx_t pg [3];
    logic          sg [3];
    logic          sat36;

    for (genvar i = 0; i < 3; i++) begin : g_lg
        smvf_fmul u_g (.aclk, .en, .a(gs_reg[i]), .b(aread), .p(pg[i]), .sat(sg[i]));
    end

    smvf_dly #(.W(1), .N(smvf_pkg::MUL_LAT)) u_sat36 (
        .aclk, .en, .d(sat32_reg), .q(sat36)
    );

    // Stage 37: output clipping, slot-three zeroing, output register
    logic signed [47:0] gout [3];
    logic [47:0]        kout;
    logic               sat_fin;
    logic signed [47:0] fgx_reg, fgy_reg, fgz_reg;
    logic [47:0]        hess_reg;
    logic               sat_reg;

    always_comb begin
        sat_fin = sat36;
        for (int i = 0; i < 3; i++) begin
            sat_fin = sat_fin | sg[i];
            if (pg[i] > smvf_pkg::OUT_SMAX) begin
                sat_fin = 1'b1;
                gout[i] = smvf_pkg::OUT_SMAX[47:0];
            end else if (pg[i] < smvf_pkg::OUT_SMIN) begin
                sat_fin = 1'b1;
                gout[i] = smvf_pkg::OUT_SMIN[47:0];
            end else begin
                gout[i] = pg[i][47:0];
            end
        end
        if (k36[63]) begin
            kout = '0;
        end else if (k36 > smvf_pkg::HESS_MAX) begin
            sat_fin = 1'b1;
            kout    = smvf_pkg::HESS_MAX[47:0];
        end else begin
            kout = k36[47:0];
        end
        if (slot36 == smvf_pkg::SLOT_NONE) begin
            for (int i = 0; i < 3; i++) begin
                gout[i] = '0;
            end
            kout    = '0;
            sat_fin = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fgx_reg  <= gout[0];
            fgy_reg  <= gout[1];
            fgz_reg  <= gout[2];
            hess_reg <= kout;
            sat_reg  <= sat_fin;
        end
    end

    assign m_force_grad_x = fgx_reg;
    assign m_force_grad_y = fgy_reg;
    assign m_force_grad_z = fgz_reg;
    assign m_hessian_diag = hess_reg;
    assign m_saturated    = sat_reg;

`ifndef SYNTH
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_last_stage_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        en && vld_reg[STAGES-2] |=> m_valid)
        else $error("item lost on its way into the output register");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

[rtl/core/smvf_dly.sv]
`default_nettype none

module smvf_dly #(
    parameter int unsigned W = 64,
    parameter int unsigned N = 4
) (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);

    logic [W-1:0] sr_reg [N];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= d;
            for (int k = 1; k < N; k++) begin
                sr_reg[k] <= sr_reg[k-1];
            end
        end
    end

    assign q = sr_reg[N-1];

endmodule

`default_nettype wire

[rtl/core/smvf_fmul.sv]
`default_nettype none

// Q16 multiply, round half away from zero, clamp; four stages.
module smvf_fmul (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire smvf_pkg::fx_t a,
    input  wire smvf_pkg::fx_t b,
    output smvf_pkg::fx_t      p,
    output logic               sat
);

    smvf_pkg::fx_t abs_a, abs_b;
    logic          neg1_reg, neg2_reg, neg3_reg;
    logic [61:0]   ua_reg, ub_reg;
    logic [61:0]   p00_reg, p01_reg, p10_reg, p11_reg;
    logic [62:0]   mid;
    logic [124:0]  sum;
    logic [108:0]  mag_reg;
    logic [61:0]   mag_cl;
    smvf_pkg::fx_t p_reg;
    logic          sat_reg;

    always_comb begin
        abs_a  = a[63] ? -a : a;
        abs_b  = b[63] ? -b : b;
        mid    = {1'b0, p01_reg} + {1'b0, p10_reg};
        sum    = {63'd0, p00_reg} + {31'd0, mid, 31'd0} + {1'b0, p11_reg, 62'd0}
                 + 125'h8000;
        mag_cl = (|mag_reg[108:62]) ? smvf_pkg::FX_LIM[61:0] : mag_reg[61:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg <= a[63] ^ b[63];
            ua_reg   <= abs_a[61:0];
            ub_reg   <= abs_b[61:0];
            // 31 x 31 partial products
            neg2_reg <= neg1_reg;
            p00_reg  <= ua_reg[30:0]  * ub_reg[30:0];
            p01_reg  <= ua_reg[30:0]  * ub_reg[61:31];
            p10_reg  <= ua_reg[61:31] * ub_reg[30:0];
            p11_reg  <= ua_reg[61:31] * ub_reg[61:31];
            neg3_reg <= neg2_reg;
            mag_reg  <= sum[124:16];
            sat_reg  <= |mag_reg[108:62];
            p_reg    <= neg3_reg ? -{2'b00, mag_cl} : {2'b00, mag_cl};
        end
    end

    assign p   = p_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

[test/stvk_membrane_vertex_force_tb.sv]
`default_nettype none

module stvk_membrane_vertex_force_tb;
    import smvf_pkg::*;

    // Pipeline depth from transfer in to result; drain adds a margin on top.
    localparam int unsigned PIPE_LAT = 37;

    // Register indexes of the parameter port.
    localparam logic REG_MU     = 1'b0;
    localparam logic REG_LAMBDA = 1'b1;

    // Q16 constants used by the strain and stress terms.
    localparam fx_t Q_HALF = 64'sd32768;
    localparam fx_t Q_ONE  = 64'sd65536;
    localparam fx_t Q_TWO  = 64'sd131072;
    localparam fx_t Q_LIM  = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic signed [31:0] d1 [3];
        logic signed [31:0] d2 [3];
        logic signed [31:0] m00, m01, m10, m11;
        logic [31:0]        area;
        slot_t              slot;
    } element_t;

    typedef struct {
        logic signed [47:0] grad [3];
        logic [47:0]        hess;
        logic               sat;
    } corner_force_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic               cfg_index;
    logic [47:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_edge1_x, s_edge1_y, s_edge1_z;
    logic signed [31:0] s_edge2_x, s_edge2_y, s_edge2_z;
    logic signed [31:0] s_inv_rest_00, s_inv_rest_01, s_inv_rest_10, s_inv_rest_11;
    logic [31:0]        s_rest_area;
    logic [1:0]         s_corner_slot;
    logic               m_valid;
    logic               m_ready;
    logic signed [47:0] m_force_grad_x, m_force_grad_y, m_force_grad_z;
    logic [47:0]        m_hessian_diag;
    logic               m_saturated;

    stvk_membrane_vertex_force u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_edge1_x      (s_edge1_x),
        .s_edge1_y      (s_edge1_y),
        .s_edge1_z      (s_edge1_z),
        .s_edge2_x      (s_edge2_x),
        .s_edge2_y      (s_edge2_y),
        .s_edge2_z      (s_edge2_z),
        .s_inv_rest_00  (s_inv_rest_00),
        .s_inv_rest_01  (s_inv_rest_01),
        .s_inv_rest_10  (s_inv_rest_10),
        .s_inv_rest_11  (s_inv_rest_11),
        .s_rest_area    (s_rest_area),
        .s_corner_slot  (s_corner_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_force_grad_x (m_force_grad_x),
        .m_force_grad_y (m_force_grad_y),
        .m_force_grad_z (m_force_grad_z),
        .m_hessian_diag (m_hessian_diag),
        .m_saturated    (m_saturated)
    );

    // Clock: period 10.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor copy of the two parameter registers.
    logic [47:0] mu_q, lambda_q;

    corner_force_t expected_forces [$];
    int unsigned   fail_count;
    bit            hold_off_req;   // receiver stalls for a long stretch while set
    bit            rx_random;      // random stalls on the result side

    // ---------------------------------------------------------------------
    // Fixed-point predictor
    // ---------------------------------------------------------------------

    // Symmetric clamp to +-(2^62-1); flags any clip.
    function automatic fx_t q_clamp(input logic signed [65:0] v, inout bit sat);
        if (v > Q_LIM) begin
            sat = 1'b1;
            return Q_LIM;
        end
        if (v < -Q_LIM) begin
            sat = 1'b1;
            return -Q_LIM;
        end
        return v[63:0];
    endfunction

    function automatic fx_t q_add(input fx_t a, input fx_t b, inout bit sat);
        logic signed [65:0] s;
        s = 66'(a) + 66'(b);
        return q_clamp(s, sat);
    endfunction

    // Exact product, round to nearest with ties away from zero, then clamp.
    function automatic fx_t q_mul(input fx_t a, input fx_t b, inout bit sat);
        logic [127:0] ua, ub, p, mag;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 128'(-a) : 128'(a);
        ub  = (b < 0) ? 128'(-b) : 128'(b);
        p   = ua * ub;
        mag = (p + 128'h8000) >> 16;
        if (mag > 128'(Q_LIM)) begin
            sat = 1'b1;
            mag = 128'(Q_LIM);
        end
        return neg ? -fx_t'(mag[63:0]) : fx_t'(mag[63:0]);
    endfunction

    function automatic corner_force_t predict_corner_force(input element_t e);
        corner_force_t r;
        bit  sat;
        fx_t fc0 [3], fc1 [3];
        fx_t gx, gy, mu, lam, twomu, dd, g00, g01, g11, trg, s00, s01, s11;
        fx_t p0, p1, g, k;
        r.grad[0] = '0;
        r.grad[1] = '0;
        r.grad[2] = '0;
        r.hess    = '0;
        r.sat     = 1'b0;
        if (e.slot == SLOT_NONE)
            return r;
        sat = 1'b0;
        mu  = fx_t'({16'd0, mu_q});
        lam = fx_t'({16'd0, lambda_q});
        case (e.slot)
            SLOT_C1: begin
                gx = e.m00;
                gy = e.m01;
            end
            SLOT_C2: begin
                gx = e.m10;
                gy = e.m11;
            end
            default: begin
                gx = -(fx_t'(e.m00) + fx_t'(e.m10));
                gy = -(fx_t'(e.m01) + fx_t'(e.m11));
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            fc0[i] = q_add(q_mul(e.d1[i], e.m00, sat), q_mul(e.d2[i], e.m10, sat), sat);
            fc1[i] = q_add(q_mul(e.d1[i], e.m01, sat), q_mul(e.d2[i], e.m11, sat), sat);
        end
        dd = q_mul(fc0[0], fc0[0], sat);
        dd = q_add(dd, q_mul(fc0[1], fc0[1], sat), sat);
        dd = q_add(dd, q_mul(fc0[2], fc0[2], sat), sat);
        g00 = q_mul(Q_HALF, q_add(dd, -Q_ONE, sat), sat);
        dd = q_mul(fc0[0], fc1[0], sat);
        dd = q_add(dd, q_mul(fc0[1], fc1[1], sat), sat);
        dd = q_add(dd, q_mul(fc0[2], fc1[2], sat), sat);
        g01 = q_mul(Q_HALF, dd, sat);
        dd = q_mul(fc1[0], fc1[0], sat);
        dd = q_add(dd, q_mul(fc1[1], fc1[1], sat), sat);
        dd = q_add(dd, q_mul(fc1[2], fc1[2], sat), sat);
        g11 = q_mul(Q_HALF, q_add(dd, -Q_ONE, sat), sat);
        trg = q_add(g00, g11, sat);
        twomu = q_mul(Q_TWO, mu, sat);
        s00 = q_add(q_mul(twomu, g00, sat), q_mul(lam, trg, sat), sat);
        s01 = q_mul(twomu, g01, sat);
        s11 = q_add(q_mul(twomu, g11, sat), q_mul(lam, trg, sat), sat);
        for (int i = 0; i < 3; i++) begin
            p0 = q_add(q_mul(fc0[i], s00, sat), q_mul(fc1[i], s01, sat), sat);
            p1 = q_add(q_mul(fc0[i], s01, sat), q_mul(fc1[i], s11, sat), sat);
            g  = q_add(q_mul(p0, gx, sat), q_mul(p1, gy, sat), sat);
            g  = q_mul(g, fx_t'({32'd0, e.area}), sat);
            if (g > OUT_SMAX) begin
                sat = 1'b1;
                g = OUT_SMAX;
            end
            if (g < OUT_SMIN) begin
                sat = 1'b1;
                g = OUT_SMIN;
            end
            r.grad[i] = g[47:0];
        end
        k = q_mul(fx_t'({32'd0, e.area}), q_add(twomu, lam, sat), sat);
        k = q_mul(k, q_add(q_mul(gx, gx, sat), q_mul(gy, gy, sat), sat), sat);
        if (k < 0)
            k = '0;
        if (k > HESS_MAX) begin
            sat = 1'b1;
            k = HESS_MAX;
        end
        r.hess = k[47:0];
        r.sat  = sat;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    task automatic write_param(input logic idx, input logic [47:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_MU)
            mu_q = val;
        else
            lambda_q = val;
    endtask

    // Offer one element, hold it until the transfer, then maybe idle.
    task automatic send_element(input element_t e, input bit gaps);
        int unsigned gap;
        s_valid       <= 1'b1;
        s_edge1_x     <= e.d1[0];
        s_edge1_y     <= e.d1[1];
        s_edge1_z     <= e.d1[2];
        s_edge2_x     <= e.d2[0];
        s_edge2_y     <= e.d2[1];
        s_edge2_z     <= e.d2[2];
        s_inv_rest_00 <= e.m00;
        s_inv_rest_01 <= e.m01;
        s_inv_rest_10 <= e.m10;
        s_inv_rest_11 <= e.m11;
        s_rest_area   <= e.area;
        s_corner_slot <= e.slot;
        do @(posedge aclk); while (!s_ready);
        expected_forces.push_back(predict_corner_force(e));
        gap = gaps ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drop_valid();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait until every expected result has arrived, then let the pipe settle.
    task automatic drain();
        drop_valid();
        while (expected_forces.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LAT + 4) @(posedge aclk);
    endtask

    // Fully random element: every bit of every field toggles.
    function automatic element_t rand_element();
        element_t e;
        for (int i = 0; i < 3; i++) begin
            e.d1[i] = $urandom;
            e.d2[i] = $urandom;
        end
        e.m00  = $urandom;
        e.m01  = $urandom;
        e.m10  = $urandom;
        e.m11  = $urandom;
        e.area = $urandom;
        e.slot = slot_t'($urandom_range(0, 3));
        return e;
    endfunction

    // Small signed Q16 value within +-units.
    function automatic logic signed [31:0] q16_near(input int unsigned units);
        logic signed [31:0] v;
        v = $urandom_range(0, units * 65536);
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    // Physically plausible element: modest edges, inverse matrix and area,
    // so most results stay unclipped.
    function automatic element_t plausible_element();
        element_t e;
        for (int i = 0; i < 3; i++) begin
            e.d1[i] = q16_near(4);
            e.d2[i] = q16_near(4);
        end
        e.m00  = q16_near(3);
        e.m01  = q16_near(3);
        e.m10  = q16_near(3);
        e.m11  = q16_near(3);
        e.area = $urandom_range(0, 8 * 65536);
        e.slot = slot_t'($urandom_range(0, 3));
        return e;
    endfunction

    function automatic element_t fill_element(input logic signed [31:0] dv,
                                              input logic signed [31:0] mv,
                                              input logic [31:0] area,
                                              input slot_t slot);
        element_t e;
        for (int i = 0; i < 3; i++) begin
            e.d1[i] = dv;
            e.d2[i] = dv;
        end
        e.m00  = mv;
        e.m01  = mv;
        e.m10  = mv;
        e.m11  = mv;
        e.area = area;
        e.slot = slot;
        return e;
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Identity rest shape, field extremes, every slot including not incident.
    task automatic test_directed();
        element_t e;
        write_param(REG_MU, 48'h1_0000);
        write_param(REG_LAMBDA, 48'h2_0000);
        e = fill_element('0, '0, '0, SLOT_C0);
        e.m00 = 32'sh1_0000;
        e.m11 = 32'sh1_0000;
        e.d1[0] = 32'sh1_8000;
        e.d2[1] = 32'sh1_0000;
        e.area  = 32'h8000;
        for (int s = 0; s < 4; s++) begin
            e.slot = slot_t'(s);
            send_element(e, 1'b0);
        end
        send_element(fill_element(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, SLOT_C0),
                     1'b0);
        send_element(fill_element(32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF, SLOT_C1),
                     1'b0);
        send_element(fill_element(32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, SLOT_C2),
                     1'b0);
        send_element(fill_element(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, SLOT_NONE),
                     1'b0);
        send_element(fill_element('0, '0, '0, SLOT_C0), 1'b0);
        send_element(fill_element(32'sh1, 32'sh1, 32'h1, SLOT_C1), 1'b0);
        send_element(fill_element(-32'sh1, 32'sh1, 32'h1, SLOT_C2), 1'b0);
        // Rounding ties: half-LSB products.
        send_element(fill_element(32'sh8000, 32'sh1, 32'h1_0000, SLOT_C0), 1'b0);
        send_element(fill_element(-32'sh8000, 32'sh1, 32'h1_0000, SLOT_C1), 1'b0);
        drain();
        // Largest parameters: the stress and Hessian terms saturate.
        write_param(REG_MU, 48'hFFFF_FFFF_FFFF);
        write_param(REG_LAMBDA, 48'hFFFF_FFFF_FFFF);
        for (int s = 0; s < 4; s++)
            send_element(fill_element(32'sh2_0000, 32'sh1_0000, 32'h1_0000, slot_t'(s)),
                         1'b0);
        drain();
    endtask

    // Random elements under one parameter setting, with idling on both sides.
    task automatic test_random(input int unsigned count,
                               input logic [47:0] mu, input logic [47:0] lam);
        write_param(REG_MU, mu);
        write_param(REG_LAMBDA, lam);
        for (int unsigned n = 0; n < count; n++) begin
            if ($urandom_range(0, 4) == 0)
                send_element(rand_element(), 1'b1);
            else
                send_element(plausible_element(), (n / 40) % 2 == 0);
        end
        drain();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the pipeline fills and s_ready drops.
    task automatic test_back_pressure();
        rx_random    = 1'b0;
        hold_off_req = 1'b1;
        for (int n = 0; n < 80; n++)
            send_element(plausible_element(), 1'b0);
        hold_off_req = 1'b0;
        drain();
        // Sender pauses until every result is back, then resumes.
        for (int n = 0; n < 10; n++)
            send_element(plausible_element(), 1'b0);
        drain();
        rx_random = 1'b1;
    endtask

    // ---------------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------------

    // Ready: random stalls, a long hold-off when requested.
    initial begin
        int unsigned stall;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
            end
            stall = rx_random ? $urandom_range(0, 4) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge aclk) begin
        corner_force_t exp_f;
        if (aresetn && m_valid && m_ready) begin
            if (expected_forces.size() == 0) begin
                $display("%0t: unexpected result grad %h %h %h hess %h sat %b", $time,
                         m_force_grad_x, m_force_grad_y, m_force_grad_z,
                         m_hessian_diag, m_saturated);
                fail_count++;
            end else begin
                exp_f = expected_forces.pop_front();
                if (m_force_grad_x !== exp_f.grad[0]) begin
                    $display("%0t: force_grad_x expected %h actual %h", $time,
                             exp_f.grad[0], m_force_grad_x);
                    fail_count++;
                end
                if (m_force_grad_y !== exp_f.grad[1]) begin
                    $display("%0t: force_grad_y expected %h actual %h", $time,
                             exp_f.grad[1], m_force_grad_y);
                    fail_count++;
                end
                if (m_force_grad_z !== exp_f.grad[2]) begin
                    $display("%0t: force_grad_z expected %h actual %h", $time,
                             exp_f.grad[2], m_force_grad_z);
                    fail_count++;
                end
                if (m_hessian_diag !== exp_f.hess) begin
                    $display("%0t: hessian_diag expected %h actual %h", $time,
                             exp_f.hess, m_hessian_diag);
                    fail_count++;
                end
                if (m_saturated !== exp_f.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             exp_f.sat, m_saturated);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial begin
        fail_count    = 0;
        hold_off_req  = 1'b0;
        rx_random     = 1'b1;
        mu_q          = '0;
        lambda_q      = '0;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= REG_MU;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_edge1_x     <= '0;
        s_edge1_y     <= '0;
        s_edge1_z     <= '0;
        s_edge2_x     <= '0;
        s_edge2_y     <= '0;
        s_edge2_z     <= '0;
        s_inv_rest_00 <= '0;
        s_inv_rest_01 <= '0;
        s_inv_rest_10 <= '0;
        s_inv_rest_11 <= '0;
        s_rest_area   <= '0;
        s_corner_slot <= SLOT_C0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Parameters still at reset (zero) for the first batch.
        for (int n = 0; n < 20; n++)
            send_element(plausible_element(), 1'b1);
        drain();

        test_directed();
        test_random(500, 48'h0, 48'h0);
        test_random(500, 48'h1_8000, 48'h0_4000);
        test_random(400, 48'h40_0000, 48'h100_0000);
        test_random(300, 48'hFFFF_FFFF_FFFF, 48'h0);
        test_back_pressure();
        test_random(100, 48'h0, 48'hFFFF_FFFF_FFFF);

        if (fail_count == 0)
            $display("PASS stvk_membrane_vertex_force");
        else
            $display("FAIL stvk_membrane_vertex_force");
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("FAIL stvk_membrane_vertex_force");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/core/smvf_pkg.sv
rtl/core/smvf_dly.sv
rtl/core/smvf_fmul.sv
rtl/core/stvk_membrane_vertex_force.sv
test/stvk_membrane_vertex_force_tb.sv
